@@ hdl/gregorian_date_offset_top_macros.svh @@
// Assertion helpers for the checker file gdo_checker.sv.
`ifndef GREGORIAN_DATE_OFFSET_TOP_MACROS_SVH
`define GREGORIAN_DATE_OFFSET_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define GDO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdo check failed: label");

// Next-cycle implication, sampled on clk, off while in reset.
`define GDO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdo check failed: label");

`endif

@@ hdl/gdo_pkg.sv @@
package gdo_pkg;

    // Only the low OFF_W bits of offset_days are used: OFFSET_BITS, at most 16.
    localparam int OFFSET_BITS = 16;
    localparam int OFF_W       = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
    // Day count since 0001-01-01, wide enough for the last date plus an offset.
    localparam int SER_W       = (OFFSET_BITS > 21) ? OFFSET_BITS + 1 : 22;

    localparam logic [13:0] YEAR_MAX = 14'd9999;

    localparam logic [SER_W-1:0] DAYS_400 = SER_W'(146097);
    localparam logic [SER_W-1:0] DAYS_100 = SER_W'(36524);
    localparam logic [SER_W-1:0] DAYS_4   = SER_W'(1461);
    localparam logic [SER_W-1:0] DAYS_1   = SER_W'(365);
    // Count of 9999-12-31, plus one.
    localparam logic [SER_W-1:0] SER_END  = SER_W'(3652059);

    typedef enum logic
    {
        REQ_ADD = 1'b0,
        REQ_SUB = 1'b1
    } req_kind_t;

    typedef struct packed
    {
        logic        req_type;
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [15:0] offset_days;
    } req_item_t;

    typedef struct packed
    {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic        error;
    } rsp_item_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                4'd2:                                       len = leap ? 5'd29 : 5'd28;
                default:                                    len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

@@ hdl/gdo_alu.sv @@
module gdo_alu
(
    input  logic [gdo_pkg::SER_W-1:0] a,
    input  logic [gdo_pkg::SER_W-1:0] b,
    input  logic                      sub,
    output logic [gdo_pkg::SER_W-1:0] y,
    output logic                      carry
);

    logic [gdo_pkg::SER_W:0] ext;

    // On subtract, carry is the borrow: set when b > a.
    always_comb
    begin
        if (sub)
        begin
            ext = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            ext = {1'b0, a} + {1'b0, b};
        end
    end

    assign y     = ext[gdo_pkg::SER_W-1:0];
    assign carry = ext[gdo_pkg::SER_W];

endmodule

@@ hdl/gregorian_date_offset_top.sv @@
// channel  | valid     | ready     | payload
// request  | req_valid | req_ready | req (gdo_pkg::req_item_t)
// response | rsp_valid | rsp_ready | rsp (gdo_pkg::rsp_item_t)
//
// Each item runs through a state sequence from acceptance to rsp_valid: the date is turned into a
// day count and back by repeated add/subtract of 400-, 100-, 4- and 1-year spans and month
// lengths through one shared adder; the 400-year and 4-year loops set most of the run time.
// A bad year or month goes straight from acceptance to ST_DONE, a bad day from the day check.
// req_ready is high only when idle, so a stalled response stalls the input.
// rst_n clears the sequencer and the response valid; rsp holds while stalled.
module gregorian_date_offset_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  gdo_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output gdo_pkg::rsp_item_t  rsp
);

    localparam int SW = gdo_pkg::SER_W;

    typedef enum logic [14:0]
    {
        ST_IDLE  = 15'b000000000000001,
        ST_T400  = 15'b000000000000010,
        ST_T100  = 15'b000000000000100,
        ST_T4    = 15'b000000000001000,
        ST_T1    = 15'b000000000010000,
        ST_VCHK  = 15'b000000000100000,
        ST_TMON  = 15'b000000001000000,
        ST_APPLY = 15'b000000010000000,
        ST_RCHK  = 15'b000000100000000,
        ST_R400  = 15'b000001000000000,
        ST_R100  = 15'b000010000000000,
        ST_R4    = 15'b000100000000000,
        ST_R1    = 15'b001000000000000,
        ST_RMON  = 15'b010000000000000,
        ST_DONE  = 15'b100000000000000
    } state_t;

    state_t                   state_reg, state_next;
    logic                     sub_reg, sub_next;
    logic [3:0]               mon_in_reg, mon_in_next;
    logic [4:0]               day_in_reg, day_in_next;
    logic [gdo_pkg::OFF_W-1:0] off_reg, off_next;
    logic [13:0]              p_reg, p_next;
    logic [13:0]              yr_reg, yr_next;
    logic [SW-1:0]            acc_reg, acc_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic                     b3_reg, b3_next;
    logic                     leap_reg, leap_next;
    logic [3:0]               mon_reg, mon_next;
    logic                     err_reg, err_next;
    logic                     borrow_reg, borrow_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    gdo_pkg::rsp_item_t       rsp_reg, rsp_next;

    logic [SW-1:0]            alu_b;
    logic                     alu_sub;
    logic [SW-1:0]            alu_y;
    logic                     alu_c;
    logic [4:0]               cur_len;
    logic                     req_fire;

    gdo_alu u_alu
    (
        .a     (acc_reg),
        .b     (alu_b),
        .sub   (alu_sub),
        .y     (alu_y),
        .carry (alu_c)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cur_len   = gdo_pkg::month_len(mon_reg, leap_reg);

    // Operand select for the shared adder.
    always_comb
    begin
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_T400:  alu_b = gdo_pkg::DAYS_400;
            ST_T100:  alu_b = gdo_pkg::DAYS_100;
            ST_T4:    alu_b = gdo_pkg::DAYS_4;
            ST_T1:    alu_b = gdo_pkg::DAYS_1;
            ST_TMON:
            begin
                if (mon_reg < mon_in_reg)
                begin
                    alu_b = SW'(cur_len);
                end
                else
                begin
                    alu_b = SW'(day_in_reg - 5'd1);
                end
            end
            ST_APPLY:
            begin
                alu_b   = SW'(off_reg);
                alu_sub = (sub_reg == gdo_pkg::REQ_SUB);
            end
            ST_RCHK:
            begin
                alu_b   = gdo_pkg::SER_END;
                alu_sub = 1'b1;
            end
            ST_R400:
            begin
                alu_b   = gdo_pkg::DAYS_400;
                alu_sub = 1'b1;
            end
            ST_R100:
            begin
                alu_b   = gdo_pkg::DAYS_100;
                alu_sub = 1'b1;
            end
            ST_R4:
            begin
                alu_b   = gdo_pkg::DAYS_4;
                alu_sub = 1'b1;
            end
            ST_R1:
            begin
                alu_b   = gdo_pkg::DAYS_1;
                alu_sub = 1'b1;
            end
            ST_RMON:
            begin
                alu_b   = SW'(cur_len);
                alu_sub = 1'b1;
            end
            ST_IDLE, ST_VCHK, ST_DONE:
            begin
                alu_b   = '0;
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        sub_next       = sub_reg;
        mon_in_next    = mon_in_reg;
        day_in_next    = day_in_reg;
        off_next       = off_reg;
        p_next         = p_reg;
        yr_next        = yr_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        b3_next        = b3_reg;
        leap_next      = leap_reg;
        mon_next       = mon_reg;
        err_next       = err_reg;
        borrow_next    = borrow_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    sub_next    = req.req_type;
                    mon_in_next = req.in_month;
                    day_in_next = req.in_day;
                    off_next    = req.offset_days[gdo_pkg::OFF_W-1:0];
                    p_next      = req.in_year - 14'd1;
                    acc_next    = '0;
                    cnt_next    = '0;
                    err_next    = 1'b0;
                    if (req.in_year == 14'd0 || req.in_year > gdo_pkg::YEAR_MAX ||
                        req.in_month == 4'd0 || req.in_month > 4'd12)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_T400;
                    end
                end
            end
            ST_T400:
            begin
                if (p_reg >= 14'd400)
                begin
                    p_next   = p_reg - 14'd400;
                    acc_next = alu_y;
                end
                else
                begin
                    state_next = ST_T100;
                end
            end
            ST_T100:
            begin
                if (p_reg >= 14'd100)
                begin
                    p_next   = p_reg - 14'd100;
                    acc_next = alu_y;
                    cnt_next = cnt_reg + 5'd1;
                end
                else
                begin
                    b3_next    = (cnt_reg == 5'd3);
                    cnt_next   = '0;
                    state_next = ST_T4;
                end
            end
            ST_T4:
            begin
                if (p_reg >= 14'd4)
                begin
                    p_next   = p_reg - 14'd4;
                    acc_next = alu_y;
                    cnt_next = cnt_reg + 5'd1;
                end
                else
                begin
                    // Leap when the year is 4k and not a plain century.
                    leap_next  = (p_reg == 14'd3) && ((cnt_reg != 5'd24) || b3_reg);
                    state_next = ST_T1;
                end
            end
            ST_T1:
            begin
                if (p_reg != 14'd0)
                begin
                    p_next   = p_reg - 14'd1;
                    acc_next = alu_y;
                end
                else
                begin
                    state_next = ST_VCHK;
                end
            end
            ST_VCHK:
            begin
                mon_next = 4'd1;
                if (day_in_reg == 5'd0 ||
                    day_in_reg > gdo_pkg::month_len(mon_in_reg, leap_reg))
                begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_TMON;
                end
            end
            ST_TMON:
            begin
                acc_next = alu_y;
                if (mon_reg < mon_in_reg)
                begin
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                acc_next    = alu_y;
                borrow_next = (sub_reg == gdo_pkg::REQ_SUB) && alu_c;
                state_next  = ST_RCHK;
            end
            ST_RCHK:
            begin
                // Drop results before year 1 or past 9999-12-31.
                if (borrow_reg || !alu_c)
                begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    yr_next    = 14'd1;
                    cnt_next   = '0;
                    state_next = ST_R400;
                end
            end
            ST_R400:
            begin
                if (!alu_c)
                begin
                    acc_next = alu_y;
                    yr_next  = yr_reg + 14'd400;
                end
                else
                begin
                    state_next = ST_R100;
                end
            end
            ST_R100:
            begin
                if (!alu_c && cnt_reg < 5'd3)
                begin
                    acc_next = alu_y;
                    yr_next  = yr_reg + 14'd100;
                    cnt_next = cnt_reg + 5'd1;
                end
                else
                begin
                    b3_next    = (cnt_reg == 5'd3);
                    cnt_next   = '0;
                    state_next = ST_R4;
                end
            end
            ST_R4:
            begin
                if (!alu_c)
                begin
                    acc_next = alu_y;
                    yr_next  = yr_reg + 14'd4;
                    cnt_next = cnt_reg + 5'd1;
                end
                else
                begin
                    // Hold the plain-century mark in leap for the last step.
                    leap_next  = (cnt_reg != 5'd24) || b3_reg;
                    cnt_next   = '0;
                    state_next = ST_R1;
                end
            end
            ST_R1:
            begin
                if (!alu_c && cnt_reg < 5'd3)
                begin
                    acc_next = alu_y;
                    yr_next  = yr_reg + 14'd1;
                    cnt_next = cnt_reg + 5'd1;
                end
                else
                begin
                    leap_next  = (cnt_reg == 5'd3) && leap_reg;
                    mon_next   = 4'd1;
                    state_next = ST_RMON;
                end
            end
            ST_RMON:
            begin
                if (!alu_c && mon_reg < 4'd12)
                begin
                    acc_next = alu_y;
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        rsp_next = '{out_year: 14'd0, out_month: 4'd0, out_day: 5'd0,
                                     error: 1'b1};
                    end
                    else
                    begin
                        rsp_next = '{out_year: yr_reg, out_month: mon_reg,
                                     out_day: acc_reg[4:0] + 5'd1, error: 1'b0};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_reg    <= sub_next;
        mon_in_reg <= mon_in_next;
        day_in_reg <= day_in_next;
        off_reg    <= off_next;
        p_reg      <= p_next;
        yr_reg     <= yr_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        b3_reg     <= b3_next;
        leap_reg   <= leap_next;
        mon_reg    <= mon_next;
        err_reg    <= err_next;
        borrow_reg <= borrow_next;
        rsp_reg    <= rsp_next;
    end

endmodule

@@ hdl/gdo_checker.sv @@
`include "gregorian_date_offset_top_macros.svh"

module gdo_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input gdo_pkg::rsp_item_t rsp
);

    // A stalled response holds.
    `GDO_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
    // The block is busy right after taking an item.
    `GDO_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    // An item never turns into a response in the cycle after it is taken.
    `GDO_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready && !rsp_valid, !rsp_valid)
    // Error responses carry an all-zero date.
    `GDO_ASSERT_NOW(a_err_zero, rsp_valid && rsp.error,
        rsp.out_year == 14'd0 && rsp.out_month == 4'd0 && rsp.out_day == 5'd0)

endmodule

bind gregorian_date_offset_top gdo_checker u_gdo_checker (.*);
